@@ rtl/ucds_pkg.sv @@
// shared types, constants and the descriptor decode function for the descriptor scanner
package ucds_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 256;

  localparam logic [7:0] DESC_TYPE_INTERFACE = 8'h04;
  localparam logic [7:0] DESC_TYPE_ENDPOINT  = 8'h05;
  localparam logic [1:0] EP_ATTR_INTERRUPT   = 2'b11;
  localparam logic [7:0] LENGTH_CAP          = 8'd255;
  localparam logic [8:0] FIRST_DESC_OFFSET   = 9'd9;
  localparam logic [15:0] DEFAULT_MPS        = 16'd8;

  // offsets inside one descriptor
  localparam logic [9:0] HDR_SPAN   = 10'd2;
  localparam logic [9:0] EP_SPAN    = 10'd7;
  localparam logic [9:0] IFACE_SPAN = 10'd9;
  localparam logic [9:0] POS_LEN_LO = 10'd2;
  localparam logic [9:0] POS_LEN_HI = 10'd3;
  localparam logic [9:0] POS_CFG    = 10'd5;

  // bytes 0..5 of a descriptor are all that decode needs
  localparam int unsigned WIN_BYTES = 6;

  localparam int unsigned OUT_TDATA_W = 48;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  total_length;
    logic [7:0]  configuration_value;
    logic [7:0]  interface_class;
    logic [15:0] endpoint_max_packet;
    logic [3:0]  endpoint_number;
  } result_t;

  typedef struct packed {
    logic        iface;
    logic [7:0]  cls;
    logic        ep;
    logic [3:0]  num;
    logic [15:0] mps;
  } desc_hit_t;

  // decode one descriptor from its first six bytes, start offset q and total length
  function automatic desc_hit_t eval_desc(logic [WIN_BYTES-1:0][7:0] d, logic [9:0] q,
                                          logic [7:0] total);
    desc_hit_t  r;
    logic [9:0] t10;
    t10    = {2'b00, total};
    r.iface = (d[1] == DESC_TYPE_INTERFACE) && ((q + IFACE_SPAN) <= t10);
    r.cls   = d[5];
    r.ep    = (d[1] == DESC_TYPE_ENDPOINT) && ((q + EP_SPAN) <= t10) && d[2][7]
              && (d[3][1:0] == EP_ATTR_INTERRUPT);
    r.num   = d[2][3:0];
    r.mps   = {d[5], d[4]};
    return r;
  endfunction

endpackage

@@ rtl/ucds_in_stage.sv @@
// input register for descriptor bytes
module ucds_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // data_byte
  input  logic                s_tlast,   // last_byte
  input  logic                pop,
  output logic                item_valid,
  output ucds_pkg::in_item_t  item
);
  import ucds_pkg::*;

  assign s_tready = !item_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      item_valid <= 1'b1;
    end else if (pop) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.data <= s_tdata;
      item.last <= s_tlast;
    end
  end

endmodule

@@ rtl/ucds_walker.sv @@
// scan state: header chain, six byte window and captured fields
module ucds_walker #(
  parameter int unsigned BufferBytes = ucds_pkg::BUFFER_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               fire,
  input  ucds_pkg::in_item_t item,
  output ucds_pkg::result_t  result
);
  import ucds_pkg::*;

  localparam int unsigned PosW = $clog2(BufferBytes + 1);

  logic [PosW-1:0]  pos;
  logic [7:0]       len_lo;
  logic             len_hi_nz;
  logic [7:0]       cfg_val;
  logic [8:0]       next_hdr;
  logic             stopped;
  logic [4:0][7:0]  win;
  logic [4:0]       hdr;
  logic             cls_seen;
  logic [7:0]       found_cls;
  logic [3:0]       found_num;
  logic [15:0]      found_mps;
  logic [7:0]       default_class;

  logic             byte_ok;
  logic [9:0]       p10;
  logic [7:0]       cur;
  logic [7:0]       lo_cur;
  logic             hi_cur;
  logic [7:0]       total_cur;
  logic             at_hdr;
  logic             is_hdr;
  logic [WIN_BYTES-1:0][7:0] w6;
  logic [WIN_BYTES-1:0]      h6;
  logic [WIN_BYTES-1:0][WIN_BYTES-1:0][7:0] dk;
  desc_hit_t        hits [WIN_BYTES];

  assign byte_ok = pos < PosW'(BufferBytes);
  assign p10     = 10'(pos);
  assign cur     = item.data;

  // length and config value, including the byte in flight
  assign lo_cur    = (byte_ok && p10 == POS_LEN_LO) ? cur : len_lo;
  assign hi_cur    = (byte_ok && p10 == POS_LEN_HI) ? (cur != 8'd0) : len_hi_nz;
  assign total_cur = hi_cur ? LENGTH_CAP : lo_cur;

  assign at_hdr = byte_ok && !stopped && (p10 == {1'b0, next_hdr});
  assign is_hdr = at_hdr && ((p10 + HDR_SPAN) <= {2'b00, total_cur}) && (cur != 8'd0);

  assign w6 = {win, cur};
  assign h6 = {hdr, is_hdr};

  // descriptor k starts k bytes back; bytes not yet seen read as zero
  always_comb begin
    dk = '0;
    for (int k = 0; k < WIN_BYTES; k++) begin
      for (int j = 0; j <= k; j++) begin
        if (j < k || byte_ok) begin
          dk[k][j] = w6[k-j];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < WIN_BYTES; k++) begin
      hits[k] = eval_desc(dk[k], p10 - 10'(k), total_cur);
    end
  end

  // result on the last byte: later descriptors in the chain win
  always_comb begin
    result.endpoint_number     = found_num;
    result.endpoint_max_packet = found_mps;
    result.interface_class     = cls_seen ? found_cls : default_class;
    for (int k = WIN_BYTES - 1; k >= 0; k--) begin
      if (h6[k] && hits[k].iface) begin
        result.interface_class = hits[k].cls;
      end
      if (h6[k] && hits[k].ep) begin
        result.endpoint_number     = hits[k].num;
        result.endpoint_max_packet = hits[k].mps;
      end
    end
    result.configuration_value = (byte_ok && p10 == POS_CFG) ? cur : cfg_val;
    result.total_length = total_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_class <= 8'd0;
    end else if (cfg_wr_en) begin
      default_class <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && item.last)) begin
      pos       <= '0;
      len_lo    <= 8'd0;
      len_hi_nz <= 1'b0;
      cfg_val   <= 8'd0;
      next_hdr  <= FIRST_DESC_OFFSET;
      stopped   <= 1'b0;
      hdr       <= '0;
      cls_seen  <= 1'b0;
      found_cls <= 8'd0;
      found_num <= 4'd0;
      found_mps <= DEFAULT_MPS;
    end else if (fire && byte_ok) begin
      pos       <= pos + 1'b1;
      len_lo    <= lo_cur;
      len_hi_nz <= hi_cur;
      if (p10 == POS_CFG) begin
        cfg_val <= cur;
      end
      if (is_hdr) begin
        next_hdr <= next_hdr + 9'(cur);
      end else if (at_hdr) begin
        stopped <= 1'b1;
      end
      hdr <= h6[4:0];
      // descriptor five bytes back is now complete
      if (h6[5] && hits[5].iface) begin
        cls_seen  <= 1'b1;
        found_cls <= hits[5].cls;
      end
      if (h6[5] && hits[5].ep) begin
        found_num <= hits[5].num;
        found_mps <= hits[5].mps;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && byte_ok) begin
      win <= w6[4:0];
    end
  end

endmodule

@@ rtl/ucds_out_stage.sv @@
// result register on the master side
module ucds_out_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  ucds_pkg::result_t             result,
  output logic                          ready,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ucds_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import ucds_pkg::*;

  result_t held;

  assign ready   = !m_tvalid || m_tready;
  assign m_tdata = {(OUT_TDATA_W - $bits(result_t))'(0), held};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

@@ rtl/usb_config_descriptor_scanner.sv @@
// top level of the configuration descriptor scanner
//
// bytes of a configuration descriptor set enter on the s_ side, one per transfer,
// starting at offset 0; s_tlast marks the final byte. on that byte one result
// leaves on the m_ side: interrupt IN endpoint number and max packet size,
// interface class, configuration value and total length clamped to 255.
// the chain is walked on the fly from offset 9; a six byte window holds the
// descriptors whose fields are still arriving, so no byte store is needed.
// throughput: one byte per cycle unless a last byte waits for the result slot,
// fixed by the single input register feeding one pass of compare and capture
// logic into the result register; the result is loaded as the last byte leaves.
// default_class is written through cfg_wr_en / cfg_wr_data, and the user must
// do so only while idle; the block does not enforce it. reset clears the scan
// state, the register and both stages; scan state also clears after each result.
// when the receiver stalls, the held result stays put; non-last bytes keep
// flowing, and a last byte waits in the input register until the result slot
// frees, which then holds off s_tready.
module usb_config_descriptor_scanner #(
  parameter int unsigned BufferBytes = ucds_pkg::BUFFER_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [7:0]                       cfg_wr_data,   // default_class
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,       // [7:0] data_byte
  input  logic                             s_tlast,       // last_byte
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [3:0] endpoint_number, [19:4] endpoint_max_packet, [27:20] interface_class,
  // [35:28] configuration_value, [43:36] total_length, rest zero
  output logic [ucds_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import ucds_pkg::*;

  in_item_t item;
  logic     item_valid;
  logic     out_ready;
  logic     walk_fire;
  logic     res_load;
  result_t  result;

  // a last byte only moves on when the result slot can take it
  assign walk_fire = item_valid && (!item.last || out_ready);
  assign res_load  = walk_fire && item.last;

  ucds_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .pop        (walk_fire),
    .item_valid (item_valid),
    .item       (item)
  );

  ucds_walker #(
    .BufferBytes (BufferBytes)
  ) u_walk (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (walk_fire),
    .item        (item),
    .result      (result)
  );

  ucds_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_load),
    .result   (result),
    .ready    (out_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // a last byte never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!m_tvalid || m_tready))
    else $error("result register overwritten while stalled");

  // a taken result with no new load leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !res_load) |=> !m_tvalid)
    else $error("result shown twice");

  // input side only stalls behind a held byte
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (item_valid && item.last && m_tvalid && !m_tready))
    else $error("input stalled without a waiting last byte");

endmodule

@@ tb/sv/ucds_result_checker.sv @@
`timescale 1ns / 1ps
// checker that predicts scanner results from observed transfers and compares them
module ucds_result_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [7:0]                       cfg_wr_data,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [7:0]                       s_tdata,
  input  logic                             s_tlast,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [ucds_pkg::OUT_TDATA_W-1:0] m_tdata,
  output int                               mismatch_count,
  output int                               results_owed
);
  import ucds_pkg::*;

  localparam int StoreBytes = BUFFER_BYTES_DEF;
  localparam int LengthLimit = 255;
  localparam int FirstDescOffset = 9;
  localparam int IfaceBytes = 9;
  localparam int EpBytes = 7;

  logic [7:0] desc_store [StoreBytes];
  int         write_offset;
  int         error_total;
  logic [7:0] default_class_copy;
  result_t    owed_results [$];

  function automatic logic [7:0] stored_byte(int offset);
    if (offset < StoreBytes) return desc_store[offset];
    return 8'h00;
  endfunction

  // walk the chain held in desc_store and build the result for this set
  function automatic result_t scan_descriptor_set();
    result_t    r;
    int         total;
    int         off;
    int         dlen;
    logic [7:0] dtype;
    logic [7:0] addr;
    logic [7:0] attr;
    total = int'({stored_byte(3), stored_byte(2)});
    if (total > LengthLimit) total = LengthLimit;
    r.total_length        = total[7:0];
    r.configuration_value = stored_byte(5);
    r.interface_class     = default_class_copy;
    r.endpoint_number     = 4'd0;
    r.endpoint_max_packet = DEFAULT_MPS;
    off = FirstDescOffset;
    while (off + 2 <= total) begin
      dlen  = int'(stored_byte(off));
      dtype = stored_byte(off + 1);
      if (dlen == 0) break;
      if (dtype == DESC_TYPE_INTERFACE && off + IfaceBytes <= total) begin
        r.interface_class = stored_byte(off + 5);
      end else if (dtype == DESC_TYPE_ENDPOINT && off + EpBytes <= total) begin
        addr = stored_byte(off + 2);
        attr = stored_byte(off + 3);
        if (addr[7] && attr[1:0] == EP_ATTR_INTERRUPT) begin
          r.endpoint_number     = addr[3:0];
          r.endpoint_max_packet = {stored_byte(off + 5), stored_byte(off + 4)};
        end
      end
      off += dlen;
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_total++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t seen;
    result_t want;
    if (rst) begin
      for (int i = 0; i < StoreBytes; i++) desc_store[i] = 8'h00;
      write_offset       = 0;
      error_total        = 0;
      default_class_copy = 8'h00;
      owed_results.delete();
    end else begin
      if (cfg_wr_en) default_class_copy = cfg_wr_data;
      if (s_tvalid && s_tready) begin
        // offsets past the store are dropped
        if (write_offset < StoreBytes) begin
          desc_store[write_offset] = s_tdata;
          write_offset++;
        end
        if (s_tlast) begin
          owed_results.push_back(scan_descriptor_set());
          for (int i = 0; i < StoreBytes; i++) desc_store[i] = 8'h00;
          write_offset = 0;
        end
      end
      if (m_tvalid && m_tready) begin
        seen = m_tdata[$bits(result_t)-1:0];
        if (owed_results.size() == 0) begin
          $error("result transfer with nothing expected: %h", m_tdata);
          error_total++;
        end else begin
          want = owed_results.pop_front();
          compare_field("endpoint_number", 32'(want.endpoint_number),
                        32'(seen.endpoint_number));
          compare_field("endpoint_max_packet", 32'(want.endpoint_max_packet),
                        32'(seen.endpoint_max_packet));
          compare_field("interface_class", 32'(want.interface_class),
                        32'(seen.interface_class));
          compare_field("configuration_value", 32'(want.configuration_value),
                        32'(seen.configuration_value));
          compare_field("total_length", 32'(want.total_length),
                        32'(seen.total_length));
        end
      end
    end
    results_owed   <= owed_results.size();
    mismatch_count <= error_total;
  end

endmodule

@@ tb/sv/tb_usb_config_descriptor_scanner.sv @@
`timescale 1ns / 1ps
// top of the descriptor scanner testbench: clock, reset, stimulus and verdict
module tb_usb_config_descriptor_scanner;
  import ucds_pkg::*;

  localparam int RandomItems = 700;
  localparam int MinFrames   = 45;
  localparam int CycleLimit  = 300000;

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   cfg_wr_en   = 1'b0;
  logic [7:0]             cfg_wr_data = 8'h00;
  logic                   s_tvalid    = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata     = 8'h00;
  logic                   s_tlast     = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready    = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int mismatch_count;
  int results_owed;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycle_count = 0;
  int items_sent  = 0;
  int frames_sent = 0;

  // bytes of the descriptor set currently being built and sent
  logic [7:0] frame_bytes [$];

  usb_config_descriptor_scanner u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  ucds_result_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver side: random stalls at the rate of the current phase
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one byte transfer, with random sender gaps in front of it
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= is_last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // hold the sender until every expected result has come out, then let
  // the pipeline settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  // register writes only happen with the block idle
  task automatic write_default_class(input logic [7:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // append one sub-descriptor: interface, endpoint, some other type, or a
  // zero length that ends the chain; lengths are sometimes short so fields
  // overlap the next descriptor
  task automatic add_descriptor();
    int         pick;
    int         dlen;
    int         n;
    logic [7:0] dtype;
    logic [7:0] addr;
    logic [7:0] attr;
    pick = $urandom_range(99);
    addr = 8'($urandom_range(255));
    attr = 8'($urandom_range(255));
    if ($urandom_range(3) != 0) addr[7] = 1'b1;
    if ($urandom_range(3) != 0) attr[1:0] = EP_ATTR_INTERRUPT;
    if (pick < 38) begin
      dtype = DESC_TYPE_INTERFACE;
      dlen  = ($urandom_range(9) == 0) ? $urandom_range(1, 8) : 9;
    end else if (pick < 76) begin
      dtype = DESC_TYPE_ENDPOINT;
      dlen  = ($urandom_range(9) == 0) ? $urandom_range(1, 9) : 7;
    end else if (pick < 95) begin
      dtype = 8'($urandom_range(255));
      dlen  = $urandom_range(2, 12);
    end else begin
      dtype = 8'($urandom_range(255));
      dlen  = 0;
    end
    n = (dlen < 2) ? 2 : dlen;
    frame_bytes.push_back(dlen[7:0]);
    frame_bytes.push_back(dtype);
    for (int k = 2; k < n; k++) begin
      if (dtype == DESC_TYPE_ENDPOINT && k == 2) begin
        frame_bytes.push_back(addr);
      end else if (dtype == DESC_TYPE_ENDPOINT && k == 3) begin
        frame_bytes.push_back(attr);
      end else begin
        frame_bytes.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  // build one random descriptor set: mostly well formed chains with random
  // content and a patched total length, some noise, some cut short or padded
  task automatic build_frame(input bit go_long);
    int kind;
    int ndesc;
    int full_len;
    int tot;
    int pick;
    frame_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 12 && !go_long) begin
      // noise: a few random bytes, often too short to hold a header
      repeat ($urandom_range(1, 16)) frame_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    frame_bytes.push_back(8'd9);
    frame_bytes.push_back(8'd2);
    repeat (7) frame_bytes.push_back(8'($urandom_range(255)));
    if (go_long) begin
      // runs past the store size, total above the clamp
      while (frame_bytes.size() < 280) add_descriptor();
    end else begin
      ndesc = $urandom_range(1, 5);
      repeat (ndesc) add_descriptor();
    end
    full_len = frame_bytes.size();
    pick = $urandom_range(99);
    if (go_long || pick < 65) begin
      tot = full_len;
    end else if (pick < 78) begin
      tot = full_len - $urandom_range(0, 12);
    end else if (pick < 88) begin
      tot = $urandom_range(0, 300);
    end else begin
      tot = int'({8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))});
    end
    frame_bytes[2] = tot[7:0];
    frame_bytes[3] = tot[15:8];
    // delivery: whole set, cut short (missing bytes), or padded past the total
    pick = $urandom_range(99);
    if (!go_long && pick >= 72 && pick < 86) begin
      tot = $urandom_range(1, full_len);
      while (frame_bytes.size() > tot) void'(frame_bytes.pop_back());
    end else if (pick >= 86) begin
      repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  initial begin : stimulus
    int  phase;
    bit  mid_write_done;
    bit  long_done;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_default_class(8'hFF);
    tx_idle_pct = 9;
    rx_idle_pct = 56;

    // a lone last byte: every field from missing bytes, class from the register
    frame_bytes = '{8'hFF};
    send_frame();
    // exact-fit set with extreme fields: class 255, endpoint 15 with mps 65535
    frame_bytes = '{8'd9, 8'd2, 8'd25, 8'd0, 8'd1, 8'hFF, 8'h00, 8'h80, 8'd50,
                    8'd9, DESC_TYPE_INTERFACE, 8'h00, 8'h00, 8'h01, 8'hFF,
                    8'h00, 8'h00, 8'h00,
                    8'd7, DESC_TYPE_ENDPOINT, 8'h8F, 8'h03, 8'hFF, 8'hFF, 8'h01};
    send_frame();

    long_done = 1'b0;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 9;
          rx_idle_pct = 56;
          write_default_class(8'h00);
        end
        1: begin
          tx_idle_pct = 56;
          rx_idle_pct = 9;
          write_default_class(8'($urandom_range(255)));
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          write_default_class(8'hFF);
        end
      endcase
      mid_write_done = 1'b0;
      while (items_sent < RandomItems * (phase + 1) / 3 ||
             frames_sent < MinFrames * (phase + 1) / 3) begin
        build_frame(phase == 1 && !long_done);
        if (phase == 1) long_done = 1'b1;
        send_frame();
        items_sent  += frame_bytes.size();
        frames_sent += 1;
        // sender holds off now and then until the output side is empty
        if (frames_sent % 9 == 0) wait_drained();
        if (!mid_write_done && items_sent >= RandomItems * (2 * phase + 1) / 6) begin
          write_default_class(8'($urandom_range(255)));
          mid_write_done = 1'b1;
        end
      end
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
